// ===== rtl/fchr_pkg.sv =====
package fchr_pkg;

    localparam int FracW    = 16;
    localparam int UnitW    = FracW + 1;
    localparam int HueW     = 16;
    localparam int Hue6W    = 19;
    localparam int SampleW  = 32;
    localparam int CfgDataW = 32;
    localparam int AddrW    = 3;
    localparam int InDataW  = 88;
    localparam int OutDataW = 24;
    localparam int ByteW    = 8;

    localparam logic [UnitW-1:0]    QOne            = 17'h1_0000;
    localparam logic [CfgDataW-1:0] LowBoundReset   = 32'h0000_0000;
    localparam logic [CfgDataW-1:0] RangeScaleReset = 32'h0001_0000;

    typedef enum logic
    {
        REG_LOW_BOUND   = 1'b0,
        REG_RANGE_SCALE = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0]
    {
        SECT_0 = 3'd0,
        SECT_1 = 3'd1,
        SECT_2 = 3'd2,
        SECT_3 = 3'd3,
        SECT_4 = 3'd4,
        SECT_5 = 3'd5
    } sector_t;

    // hue times six in Q3.16, saturation and value in Q1.16
    typedef struct packed
    {
        logic [Hue6W-1:0] h6;
        logic [UnitW-1:0] sat;
        logic [UnitW-1:0] val;
    } hsv_req_t;

endpackage

// ===== rtl/fchr_cfg_regs.sv =====
module fchr_cfg_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fchr_pkg::AddrW-1:0]     paddr,
    input  logic [fchr_pkg::CfgDataW-1:0]  pwdata,
    output logic [fchr_pkg::CfgDataW-1:0]  prdata,
    output logic                           pready,
    output logic [fchr_pkg::CfgDataW-1:0]  low_bound,
    output logic [fchr_pkg::CfgDataW-1:0]  range_scale
);

    logic [fchr_pkg::CfgDataW-1:0] low_bound_reg;
    logic [fchr_pkg::CfgDataW-1:0] range_scale_reg;
    fchr_pkg::reg_idx_t            reg_idx;
    logic                          wr_en;

    assign reg_idx = fchr_pkg::reg_idx_t'(paddr[2]);
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_bound_reg   <= fchr_pkg::LowBoundReset;
            range_scale_reg <= fchr_pkg::RangeScaleReset;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                fchr_pkg::REG_LOW_BOUND:   low_bound_reg   <= pwdata;
                fchr_pkg::REG_RANGE_SCALE: range_scale_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            fchr_pkg::REG_LOW_BOUND:   prdata = low_bound_reg;
            fchr_pkg::REG_RANGE_SCALE: prdata = range_scale_reg;
            default:                   prdata = '0;
        endcase
    end

    assign low_bound   = low_bound_reg;
    assign range_scale = range_scale_reg;

endmodule

// ===== rtl/fchr_norm.sv =====
module fchr_norm
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           mode,
    input  logic [fchr_pkg::SampleW-1:0]   sample,
    input  logic [fchr_pkg::HueW-1:0]      hue_in,
    input  logic [fchr_pkg::UnitW-1:0]     saturation,
    input  logic [fchr_pkg::UnitW-1:0]     brightness,
    input  logic [fchr_pkg::CfgDataW-1:0]  low_bound,
    input  logic [fchr_pkg::CfgDataW-1:0]  range_scale,
    output logic                           out_valid,
    input  logic                           out_ready,
    output fchr_pkg::hsv_req_t             out_req
);

    localparam int DiffW = fchr_pkg::SampleW + 1;
    localparam int ProdW = fchr_pkg::FracW + fchr_pkg::CfgDataW;

    logic en1, en2, en3;

    // stage 1: offset
    logic                          v1_reg;
    logic                          mode1_reg;
    logic [DiffW-1:0]              d1_reg;
    logic [fchr_pkg::HueW-1:0]     hue1_reg;
    logic [fchr_pkg::UnitW-1:0]    sat1_reg;
    logic [fchr_pkg::UnitW-1:0]    val1_reg;
    logic [DiffW-1:0]              d1_next;

    // stage 2: scale products
    logic                          v2_reg;
    logic                          mode2_reg;
    logic                          pos2_reg;
    logic [ProdW-1:0]              phi2_reg;
    logic [ProdW-1:0]              plo2_reg;
    logic [fchr_pkg::HueW-1:0]     hue2_reg;
    logic [fchr_pkg::UnitW-1:0]    sat2_reg;
    logic [fchr_pkg::UnitW-1:0]    val2_reg;

    // stage 3: clamp and hue
    logic                          v3_reg;
    fchr_pkg::hsv_req_t            req3_reg;
    fchr_pkg::hsv_req_t            req3_next;
    logic [ProdW:0]                n_sum;
    logic [fchr_pkg::UnitW-1:0]    n_frac;

    assign en3      = !v3_reg | out_ready;
    assign en2      = !v2_reg | en3;
    assign en1      = !v1_reg | en2;
    assign in_ready = en1;

    assign d1_next = {sample[fchr_pkg::SampleW-1], sample}
                   - {low_bound[fchr_pkg::CfgDataW-1], low_bound};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= in_valid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            mode1_reg <= mode;
            d1_reg    <= d1_next;
            hue1_reg  <= hue_in;
            sat1_reg  <= (saturation > fchr_pkg::QOne) ? fchr_pkg::QOne : saturation;
            val1_reg  <= (brightness > fchr_pkg::QOne) ? fchr_pkg::QOne : brightness;
        end
        if (en2)
        begin
            mode2_reg <= mode1_reg;
            pos2_reg  <= !d1_reg[DiffW-1] && (d1_reg != '0);
            // a positive offset fits in 32 bits: split into high and low halves
            phi2_reg  <= {{(ProdW-16){1'b0}}, d1_reg[31:16]}
                       * {{(ProdW-fchr_pkg::CfgDataW){1'b0}}, range_scale};
            plo2_reg  <= {{(ProdW-16){1'b0}}, d1_reg[15:0]}
                       * {{(ProdW-fchr_pkg::CfgDataW){1'b0}}, range_scale};
            hue2_reg  <= hue1_reg;
            sat2_reg  <= sat1_reg;
            val2_reg  <= val1_reg;
        end
        if (en3)
            req3_reg <= req3_next;
    end

    always_comb
    begin
        n_sum = {1'b0, phi2_reg} + {17'd0, plo2_reg[ProdW-1:16]};
        if (!pos2_reg)
            n_frac = '0;
        else if (n_sum > {{(ProdW-16){1'b0}}, fchr_pkg::QOne})
            n_frac = fchr_pkg::QOne;
        else
            n_frac = n_sum[fchr_pkg::UnitW-1:0];

        if (mode2_reg)
        begin
            req3_next.h6  = {1'b0, hue2_reg, 2'b00} + {2'b00, hue2_reg, 1'b0};
            req3_next.sat = sat2_reg;
            req3_next.val = val2_reg;
        end
        else
        begin
            req3_next.h6  = {(fchr_pkg::QOne - n_frac), 2'b00};
            req3_next.sat = fchr_pkg::QOne;
            req3_next.val = fchr_pkg::QOne;
        end
    end

    assign out_valid = v3_reg;
    assign out_req   = req3_reg;

endmodule

// ===== rtl/fchr_hsv.sv =====
module fchr_hsv
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  fchr_pkg::hsv_req_t          in_req,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [fchr_pkg::ByteW-1:0]  red,
    output logic [fchr_pkg::ByteW-1:0]  green,
    output logic [fchr_pkg::ByteW-1:0]  blue
);

    localparam int UW = fchr_pkg::UnitW;
    localparam int PW = 2 * UW;

    // ch*255 as ch*256 - ch; for a full-scale channel ch*256 wraps to zero in 24 bits
    function automatic logic [fchr_pkg::ByteW-1:0] to_byte(input logic [UW-1:0] ch);
        logic [23:0] prod;
        begin
            prod    = {ch[15:0], 8'd0} - {7'd0, ch};
            to_byte = prod[23:16];
        end
    endfunction

    logic en4, en5, en6;

    // stage 4: s*f, s*(1-f), p
    logic               v4_reg;
    fchr_pkg::sector_t  sect4_reg;
    logic               gray4_reg;
    logic [UW-1:0]      val4_reg;
    logic [UW-1:0]      a4_reg;
    logic [UW-1:0]      b4_reg;
    logic [UW-1:0]      p4_reg;
    logic [15:0]        frac;
    logic [UW-1:0]      frac_inv;
    logic [PW-1:0]      sf_prod;
    logic [PW-1:0]      sg_prod;
    logic [PW-1:0]      p_prod;

    // stage 5: q, t
    logic               v5_reg;
    fchr_pkg::sector_t  sect5_reg;
    logic               gray5_reg;
    logic [UW-1:0]      val5_reg;
    logic [UW-1:0]      p5_reg;
    logic [UW-1:0]      q5_reg;
    logic [UW-1:0]      t5_reg;
    logic [PW-1:0]      q_prod;
    logic [PW-1:0]      t_prod;

    // stage 6: channel select and byte scaling
    logic                       v6_reg;
    logic [fchr_pkg::ByteW-1:0] red_reg, green_reg, blue_reg;
    logic [UW-1:0]              r_ch, g_ch, b_ch;

    assign en6      = !v6_reg | out_ready;
    assign en5      = !v5_reg | en6;
    assign en4      = !v4_reg | en5;
    assign in_ready = en4;

    assign frac     = in_req.h6[15:0];
    assign frac_inv = fchr_pkg::QOne - {1'b0, frac};
    assign sf_prod  = in_req.sat * {1'b0, frac};
    assign sg_prod  = in_req.sat * frac_inv;
    assign p_prod   = in_req.val * (fchr_pkg::QOne - in_req.sat);
    assign q_prod   = val4_reg * a4_reg;
    assign t_prod   = val4_reg * b4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (en4)
                v4_reg <= in_valid;
            if (en5)
                v5_reg <= v4_reg;
            if (en6)
                v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            sect4_reg <= fchr_pkg::sector_t'(in_req.h6[18:16]);
            gray4_reg <= (in_req.sat == '0);
            val4_reg  <= in_req.val;
            a4_reg    <= fchr_pkg::QOne - sf_prod[32:16];
            b4_reg    <= fchr_pkg::QOne - sg_prod[32:16];
            p4_reg    <= p_prod[32:16];
        end
        if (en5)
        begin
            sect5_reg <= sect4_reg;
            gray5_reg <= gray4_reg;
            val5_reg  <= val4_reg;
            p5_reg    <= p4_reg;
            q5_reg    <= q_prod[32:16];
            t5_reg    <= t_prod[32:16];
        end
        if (en6)
        begin
            red_reg   <= to_byte(r_ch);
            green_reg <= to_byte(g_ch);
            blue_reg  <= to_byte(b_ch);
        end
    end

    always_comb
    begin
        if (gray5_reg)
        begin
            r_ch = val5_reg;
            g_ch = val5_reg;
            b_ch = val5_reg;
        end
        else
        begin
            case (sect5_reg)
                fchr_pkg::SECT_0: begin r_ch = val5_reg; g_ch = t5_reg;   b_ch = p5_reg;   end
                fchr_pkg::SECT_1: begin r_ch = q5_reg;   g_ch = val5_reg; b_ch = p5_reg;   end
                fchr_pkg::SECT_2: begin r_ch = p5_reg;   g_ch = val5_reg; b_ch = t5_reg;   end
                fchr_pkg::SECT_3: begin r_ch = p5_reg;   g_ch = q5_reg;   b_ch = val5_reg; end
                fchr_pkg::SECT_4: begin r_ch = t5_reg;   g_ch = p5_reg;   b_ch = val5_reg; end
                default:          begin r_ch = val5_reg; g_ch = p5_reg;   b_ch = q5_reg;   end
            endcase
        end
    end

    assign out_valid = v6_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

endmodule

// ===== rtl/false_color_hsv_to_rgb_core.sv =====
// Channel   Direction  Handshake                 Contents
// s_axis    in         s_tvalid / s_tready       tuser mode, tdata sample/hue/sat/value
// m_axis    out        m_tvalid / m_tready       tdata red/green/blue bytes
// apb       in         psel/penable/pready       low_bound @0x0, range_scale @0x4
//
// One pixel per clock sustained while m_tready is high; three normalize stages and
// three color stages hold the multiplier chain offset -> scale -> s*f -> v*q.
// Every stage holds its own valid bit and advances when the next one is empty or
// moving, so bubbles collapse and a stall on m_tready loses and repeats nothing.
// rst_n clears all valid bits and sets the config registers to their reset values.
module false_color_hsv_to_rgb_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [fchr_pkg::InDataW-1:0]      s_tdata,  // sample, hue_in, saturation, brightness
    input  logic                              s_tuser,  // mode
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [fchr_pkg::OutDataW-1:0]     m_tdata,  // red, green, blue
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fchr_pkg::AddrW-1:0]        paddr,
    input  logic [fchr_pkg::CfgDataW-1:0]     pwdata,
    output logic [fchr_pkg::CfgDataW-1:0]     prdata,
    output logic                              pready
);

    logic [fchr_pkg::CfgDataW-1:0] low_bound;
    logic [fchr_pkg::CfgDataW-1:0] range_scale;
    logic                          mid_valid;
    logic                          mid_ready;
    fchr_pkg::hsv_req_t            mid_req;
    logic [fchr_pkg::ByteW-1:0]    red, green, blue;
    logic                          unused_pad;

    fchr_cfg_regs u_cfg
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .low_bound   (low_bound),
        .range_scale (range_scale)
    );

    fchr_norm u_norm
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .mode        (s_tuser),
        .sample      (s_tdata[31:0]),
        .hue_in      (s_tdata[47:32]),
        .saturation  (s_tdata[64:48]),
        .brightness  (s_tdata[81:65]),
        .low_bound   (low_bound),
        .range_scale (range_scale),
        .out_valid   (mid_valid),
        .out_ready   (mid_ready),
        .out_req     (mid_req)
    );

    fchr_hsv u_hsv
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .in_req    (mid_req),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

    // pad bits of the input bus carry nothing
    assign unused_pad = ^s_tdata[fchr_pkg::InDataW-1:82];

    assign m_tdata = {blue, green, red};

endmodule
